@@ rtl/i2c_master_transfer_sequencer_macros.svh @@
// ----------------------------------------------------------------------------
// I2C transfer sequencer assertion macros
// Concurrent checks clocked on clk_i and held off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_MACROS_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define I2CS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define I2CS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/i2cs_pkg.sv @@
// ----------------------------------------------------------------------------
// I2C transfer sequencer package
// Types, codes and constants shared by the sequencer modules.
// ----------------------------------------------------------------------------
package i2cs_pkg;

  localparam int TxDepthDefault     = 32;
  localparam int MaxRxLengthDefault = 255;

  localparam int CmdW      = 3;
  localparam int InDataW   = 32;
  localparam int OutDataW  = 40;
  localparam int CfgIndexW = 2;
  localparam int CfgDataW  = 8;
  localparam int TxLenW    = 6;
  // span of the 8-bit transmit offset (tx_length minus remaining, modulo 256)
  localparam int TxIdxSpan = 256;

  localparam logic [7:0] ReadBitMask  = 8'h01;
  localparam logic [7:0] NearEndCount = 8'd3;
  localparam logic [7:0] LastCount    = 8'd1;

  typedef enum logic [1:0] {
    PhIdle = 2'd0,
    PhTx   = 2'd1,
    PhRx   = 2'd2,
    PhErr  = 2'd3
  } phase_e;

  typedef enum logic [CmdW-1:0] {
    CmdStartWr = 3'd0,
    CmdStartRd = 3'd1,
    CmdLoad    = 3'd2,
    CmdStatus  = 3'd3,
    CmdBusErr  = 3'd4
  } cmd_e;

  typedef enum logic [CfgIndexW-1:0] {
    CfgTargetAddr = 2'd0,
    CfgTxLength   = 2'd1,
    CfgRxLength   = 2'd2,
    CfgRestart    = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0]        target_address;
    logic [TxLenW-1:0] tx_length;
    logic [7:0]        rx_length;
    logic              restart_enable;
  } cfg_t;

  typedef struct packed {
    logic       start_sent;
    logic       address_sent;
    logic       byte_finished;
    logic       tx_empty;
    logic       rx_not_empty;
    logic [3:0] error_flags;
    logic [7:0] rx_data;
    logic [4:0] load_index;
    logic [7:0] load_data;
  } item_t;

  typedef struct packed {
    phase_e     phase;
    logic [7:0] remaining;
    logic       irq_on;
  } state_t;

  typedef struct packed {
    logic       start_accepted;
    logic       write_valid;
    logic [7:0] write_byte;
    logic       store_valid;
    logic [7:0] store_index;
    logic [7:0] store_byte;
    logic       request_stop;
    logic       ack_set;
    logic       ack_clear;
    logic       pos_clear;
    logic       events_enabled;
    logic [1:0] phase_out;
  } result_t;

endpackage

@@ rtl/i2c_master_transfer_sequencer.sv @@
// ----------------------------------------------------------------------------
// I2C master transfer sequencer
// Event-driven transfer control: starts, transmit loads, bus events, errors.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                accepted when
//  s_axis    in         s_axis_tvalid/tready     both high at clk_i edge
//  m_axis    out        m_axis_tvalid/tready     both high at clk_i edge
//  cfg       in         cfg_valid_i/cfg_ready_o  both high (ready always high)
//
// One item per cycle sustained while results are taken; an item passes the
// input register, decode and result register. The transmit store is a RAM
// whose read address follows the next state, so its registered data is ready
// when the next item is decoded; a load to that same entry is forwarded.
// Reset clears phase, count, event enable, config and both stage valids.
// A stalled result holds the result register; the input register still takes
// one more item, then tready drops.
// ----------------------------------------------------------------------------
`include "i2c_master_transfer_sequencer_macros.svh"

module i2c_master_transfer_sequencer #(
  parameter int TX_DEPTH      = i2cs_pkg::TxDepthDefault,
  parameter int MAX_RX_LENGTH = i2cs_pkg::MaxRxLengthDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // command(3)
  input  logic [i2cs_pkg::CmdW-1:0]      s_axis_tuser,
  // start_sent, address_sent, byte_finished, tx_empty, rx_not_empty,
  // error_flags(4), rx_data(8), load_index(5), load_data(8), zero pad(2)
  input  logic [i2cs_pkg::InDataW-1:0]   s_axis_tdata,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // start_accepted, write_valid, write_byte(8), store_valid, store_index(8),
  // store_byte(8), request_stop, ack_set, ack_clear, pos_clear,
  // events_enabled, phase_out(2), zero pad(6)
  output logic [i2cs_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [i2cs_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [i2cs_pkg::CfgDataW-1:0]  cfg_data_i
);
  import i2cs_pkg::*;

  localparam int TxAddrW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;

  cfg_t        cfg_q, cfg_d;
  logic        cfg_we;

  logic        in_valid_q;
  logic [2:0]  in_cmd_q;
  item_t       in_item_q, in_item;
  logic        in_take, advance;

  phase_e      phase_q;
  logic [7:0]  rem_q;
  logic        irq_q;
  state_t      state_cur, state_d;
  result_t     result;

  logic        out_valid_q;
  result_t     out_res_q;

  logic [TxAddrW-1:0] idx_tab [TxIdxSpan];
  logic [7:0]         rd_off;
  logic [7:0]         rem_nx;
  logic [TxAddrW-1:0] rd_addr, wr_addr;
  logic               tx_we, fwd_hit_q;
  logic [7:0]         fwd_data_q, ram_rdata, tx_byte;

  logic               in_xfer, start_open, out_start;

  // Offset-to-entry map, offset modulo the store depth
  for (genvar g = 0; g < TxIdxSpan; g++) begin : g_idx_tab
    assign idx_tab[g] = TxAddrW'(g % TX_DEPTH);
  end

  // Configuration registers
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we) begin
      unique case (cfg_index_i)
        CfgTargetAddr: cfg_d.target_address = cfg_data_i;
        CfgTxLength:   cfg_d.tx_length      = cfg_data_i[TxLenW-1:0];
        CfgRxLength:   cfg_d.rx_length      = cfg_data_i;
        CfgRestart:    cfg_d.restart_enable = cfg_data_i[0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Input register
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  assign in_item.start_sent    = s_axis_tdata[0];
  assign in_item.address_sent  = s_axis_tdata[1];
  assign in_item.byte_finished = s_axis_tdata[2];
  assign in_item.tx_empty      = s_axis_tdata[3];
  assign in_item.rx_not_empty  = s_axis_tdata[4];
  assign in_item.error_flags   = s_axis_tdata[8:5];
  assign in_item.rx_data       = s_axis_tdata[16:9];
  assign in_item.load_index    = s_axis_tdata[21:17];
  assign in_item.load_data     = s_axis_tdata[29:22];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_cmd_q  <= s_axis_tuser;
      in_item_q <= in_item;
    end
  end

  // Decode
  assign state_cur.phase     = phase_q;
  assign state_cur.remaining = rem_q;
  assign state_cur.irq_on    = irq_q;

  i2cs_decode #(
    .MAX_RX_LENGTH(MAX_RX_LENGTH)
  ) u_decode (
    .cfg_i    (cfg_q),
    .state_i  (state_cur),
    .cmd_i    (in_cmd_q),
    .item_i   (in_item_q),
    .tx_byte_i(tx_byte),
    .state_d_o(state_d),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      rem_q   <= '0;
      irq_q   <= 1'b0;
    end else if (advance) begin
      phase_q <= state_d.phase;
      rem_q   <= state_d.remaining;
      irq_q   <= state_d.irq_on;
    end
  end

  // Transmit store: read the entry the next item would fetch
  assign tx_we   = advance && (in_cmd_q == CmdLoad);
  assign wr_addr = idx_tab[{3'b000, in_item_q.load_index}];
  assign rem_nx  = advance ? state_d.remaining : rem_q;
  assign rd_off  = {2'b00, cfg_d.tx_length} - rem_nx;
  assign rd_addr = idx_tab[rd_off];

  i2cs_ram #(
    .Width(8),
    .Depth(TX_DEPTH)
  ) u_tx_ram (
    .clk_i  (clk_i),
    .we_i   (tx_we),
    .waddr_i(wr_addr),
    .wdata_i(in_item_q.load_data),
    .raddr_i(rd_addr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
    end else begin
      fwd_hit_q <= tx_we && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk_i) begin
    if (tx_we) begin
      fwd_data_q <= in_item_q.load_data;
    end
  end

  assign tx_byte = fwd_hit_q ? fwd_data_q : ram_rdata;

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0,
                          out_res_q.phase_out,
                          out_res_q.events_enabled,
                          out_res_q.pos_clear,
                          out_res_q.ack_clear,
                          out_res_q.ack_set,
                          out_res_q.request_stop,
                          out_res_q.store_byte,
                          out_res_q.store_index,
                          out_res_q.store_valid,
                          out_res_q.write_byte,
                          out_res_q.write_valid,
                          out_res_q.start_accepted};

  // Checks
  assign in_xfer    = (phase_q == PhTx) || (phase_q == PhRx);
  assign start_open = advance && (in_cmd_q == CmdStartWr || in_cmd_q == CmdStartRd) &&
                      (phase_q == PhIdle);
  assign out_start  = out_valid_q && out_res_q.start_accepted;

  `I2CS_ASSERT_SAME(a_irq_only_active, irq_q, in_xfer, "events enabled outside a transfer")
  `I2CS_ASSERT_NEXT(a_start_opens, start_open, irq_q && in_xfer, "start did not open a transfer")
  `I2CS_ASSERT_SAME(a_accept_enables, out_start, out_res_q.events_enabled, "start, events off")

endmodule

@@ rtl/i2cs_ram.sv @@
// ----------------------------------------------------------------------------
// I2C transfer sequencer RAM
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module i2cs_ram #(
  parameter int Width = 8,
  parameter int Depth = 32,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/i2cs_decode.sv @@
// ----------------------------------------------------------------------------
// I2C transfer sequencer decode
// Serves one item against the current state: next state and result fields.
// ----------------------------------------------------------------------------
module i2cs_decode #(
  parameter int MAX_RX_LENGTH = i2cs_pkg::MaxRxLengthDefault
) (
  input  i2cs_pkg::cfg_t    cfg_i,
  input  i2cs_pkg::state_t  state_i,
  input  logic [2:0]        cmd_i,
  input  i2cs_pkg::item_t   item_i,
  input  logic [7:0]        tx_byte_i,
  output i2cs_pkg::state_t  state_d_o,
  output i2cs_pkg::result_t result_o
);
  import i2cs_pkg::*;

  localparam logic [7:0] RxCap = (MAX_RX_LENGTH > 255) ? 8'd255 : 8'(MAX_RX_LENGTH);

  logic [7:0] rem, rem_dec, rx_start, tx_rem_new, rx_rem_new;
  logic       tx_take, rx_take, in_tx, in_rx, rx_single;
  state_t     st_d;

  assign rem        = state_i.remaining;
  assign rem_dec    = rem - 8'd1;
  assign in_tx      = (state_i.phase == PhTx);
  assign in_rx      = (state_i.phase == PhRx);
  assign rx_single  = (cfg_i.rx_length == 8'd1);
  assign rx_start   = (cfg_i.rx_length > RxCap) ? RxCap : cfg_i.rx_length;
  assign tx_take    = (rem != 8'd0);
  assign tx_rem_new = tx_take ? rem_dec : rem;
  assign rx_take    = (rem != NearEndCount) && (rem != 8'd0);
  assign rx_rem_new = rx_take ? rem_dec : rem;

  // Next state
  always_comb begin
    st_d = state_i;
    unique case (cmd_i)
      CmdStartWr, CmdStartRd: begin
        if (state_i.phase == PhIdle) begin
          st_d.irq_on = 1'b1;
          if (cmd_i == CmdStartWr) begin
            st_d.phase     = PhTx;
            st_d.remaining = {2'b00, cfg_i.tx_length};
          end else begin
            st_d.phase     = PhRx;
            st_d.remaining = rx_start;
          end
        end
      end
      CmdStatus: begin
        if (state_i.irq_on) begin
          priority if (item_i.start_sent || item_i.address_sent) begin
            st_d = state_i;
          end else if (item_i.byte_finished) begin
            if (in_tx && item_i.tx_empty) begin
              st_d.remaining = tx_rem_new;
              if (tx_rem_new == 8'd0) begin
                st_d.irq_on = 1'b0;
                st_d.phase  = PhIdle;
              end
            end else if (in_rx && rem == NearEndCount) begin
              st_d.remaining = rem_dec;
            end
          end else if (item_i.tx_empty) begin
            if (in_tx) begin
              st_d.remaining = tx_rem_new;
            end
          end else if (item_i.rx_not_empty) begin
            if (in_rx) begin
              st_d.remaining = rx_rem_new;
              if (rx_rem_new == 8'd0) begin
                st_d.irq_on = 1'b0;
                st_d.phase  = PhIdle;
              end
            end
          end else begin
            st_d = state_i;
          end
        end
      end
      CmdBusErr: begin
        st_d.irq_on = 1'b0;
        priority if (item_i.error_flags[0]) begin
          st_d.phase = PhErr;
        end else if (item_i.error_flags[1]) begin
          st_d.phase = PhIdle;
        end else if (|item_i.error_flags[3:2]) begin
          st_d.phase = PhErr;
        end else begin
          st_d.phase = state_i.phase;
        end
      end
      default: begin
        st_d = state_i;
      end
    endcase
  end

  assign state_d_o = st_d;

  // Result fields
  always_comb begin
    result_o = '0;
    unique case (cmd_i)
      CmdStartWr, CmdStartRd: begin
        result_o.start_accepted = (state_i.phase == PhIdle);
      end
      CmdStatus: begin
        if (state_i.irq_on) begin
          priority if (item_i.start_sent) begin
            if (in_tx) begin
              result_o.write_valid = 1'b1;
              result_o.write_byte  = cfg_i.target_address;
            end else if (in_rx) begin
              result_o.write_valid = 1'b1;
              result_o.write_byte  = cfg_i.target_address | ReadBitMask;
              result_o.ack_clear   = rx_single;
            end
          end else if (item_i.address_sent) begin
            if (in_rx) begin
              result_o.request_stop = rx_single;
              result_o.ack_set      = !rx_single;
            end
          end else if (item_i.byte_finished) begin
            if (in_tx && item_i.tx_empty) begin
              if (tx_take) begin
                result_o.write_valid = 1'b1;
                result_o.write_byte  = tx_byte_i;
              end
              result_o.request_stop = (tx_rem_new == 8'd0) && !cfg_i.restart_enable;
            end else if (in_rx && rem == NearEndCount) begin
              result_o.ack_clear   = 1'b1;
              result_o.store_valid = 1'b1;
              result_o.store_index = cfg_i.rx_length - rem;
              result_o.store_byte  = item_i.rx_data;
            end
          end else if (item_i.tx_empty) begin
            if (in_tx && tx_take) begin
              result_o.write_valid = 1'b1;
              result_o.write_byte  = tx_byte_i;
            end
          end else if (item_i.rx_not_empty) begin
            if (in_rx) begin
              if (rx_take) begin
                result_o.store_valid = 1'b1;
                result_o.store_index = cfg_i.rx_length - rem;
                result_o.store_byte  = item_i.rx_data;
                result_o.ack_clear   = (rx_rem_new == LastCount);
              end
              if (rx_rem_new == 8'd0) begin
                result_o.request_stop = (cfg_i.rx_length > 8'd1);
                result_o.pos_clear    = 1'b1;
              end
            end
          end else begin
            result_o.write_valid = 1'b0;
          end
        end
      end
      CmdBusErr: begin
        result_o.request_stop = !item_i.error_flags[0] && item_i.error_flags[1];
      end
      default: begin
        result_o.start_accepted = 1'b0;
      end
    endcase
    result_o.events_enabled = st_d.irq_on;
    result_o.phase_out      = st_d.phase;
  end

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// I2C master transfer sequencer testbench
// Streams commands and bus events into the sequencer with random gaps and
// output back-pressure. An in-bench copy of the transfer state predicts the
// result of every accepted item, and each result leaving the block is checked
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import i2cs_pkg::*;

  localparam logic [CmdW-1:0] CmdSpareLo = 3'd5;
  localparam logic [CmdW-1:0] CmdSpareHi = 3'd7;
  localparam int QuietLimit  = 5000;
  localparam int HoldCycles  = 80;
  localparam int DrainCycles = 4;

  class transfer_checker;
    logic [7:0]        tgt_addr;
    logic [TxLenW-1:0] tx_len;
    logic [7:0]        rx_len;
    logic              restart;
    phase_e            phase;
    logic [7:0]        remaining;
    logic              irq_on;
    logic [7:0]        tx_mem [TxDepthDefault];
    result_t           pending_results [$];
    int                fails;

    function new();
      tgt_addr  = '0;
      tx_len    = '0;
      rx_len    = '0;
      restart   = 1'b0;
      phase     = PhIdle;
      remaining = '0;
      irq_on    = 1'b0;
      fails     = 0;
    endfunction

    function void note_cfg(cfg_reg_e idx, logic [7:0] v);
      case (idx)
        CfgTargetAddr: tgt_addr = v;
        CfgTxLength:   tx_len = v[TxLenW-1:0];
        CfgRxLength:   rx_len = v;
        CfgRestart:    restart = v[0];
        default: ;
      endcase
    endfunction

    function logic [7:0] tx_byte();
      logic [7:0] offset;
      offset = {2'b00, tx_len} - remaining;
      return tx_mem[offset % TxDepthDefault];
    endfunction

    function void take_command(logic [CmdW-1:0] cmd, item_t it);
      result_t r;
      r = '0;
      case (cmd)
        CmdStartWr, CmdStartRd: begin
          if (phase == PhIdle) begin
            r.start_accepted = 1'b1;
            irq_on = 1'b1;
            if (cmd == CmdStartWr) begin
              phase = PhTx;
              remaining = {2'b00, tx_len};
            end else begin
              // an 8-bit length never exceeds the 255 cap
              phase = PhRx;
              remaining = rx_len;
            end
          end
        end
        CmdLoad: tx_mem[it.load_index % TxDepthDefault] = it.load_data;
        CmdStatus: begin
          if (irq_on) begin
            if (it.start_sent) begin
              if (phase == PhTx) begin
                r.write_valid = 1'b1;
                r.write_byte = tgt_addr;
              end else if (phase == PhRx) begin
                r.write_valid = 1'b1;
                r.write_byte = tgt_addr | ReadBitMask;
                if (rx_len == LastCount) r.ack_clear = 1'b1;
              end
            end else if (it.address_sent) begin
              if (phase == PhRx) begin
                if (rx_len == LastCount) r.request_stop = 1'b1;
                else r.ack_set = 1'b1;
              end
            end else if (it.byte_finished) begin
              if (phase == PhTx && it.tx_empty) begin
                if (remaining > 0) begin
                  r.write_valid = 1'b1;
                  r.write_byte = tx_byte();
                  remaining = remaining - 8'd1;
                end
                if (remaining == 0) begin
                  if (!restart) r.request_stop = 1'b1;
                  irq_on = 1'b0;
                  phase = PhIdle;
                end
              end else if (phase == PhRx) begin
                if (remaining == NearEndCount) begin
                  r.ack_clear = 1'b1;
                  r.store_valid = 1'b1;
                  r.store_index = rx_len - remaining;
                  r.store_byte = it.rx_data;
                  remaining = remaining - 8'd1;
                end
              end
            end else if (it.tx_empty) begin
              if (phase == PhTx && remaining > 0) begin
                r.write_valid = 1'b1;
                r.write_byte = tx_byte();
                remaining = remaining - 8'd1;
              end
            end else if (it.rx_not_empty) begin
              if (phase == PhRx) begin
                if (remaining != NearEndCount && remaining > 0) begin
                  r.store_valid = 1'b1;
                  r.store_index = rx_len - remaining;
                  r.store_byte = it.rx_data;
                  remaining = remaining - 8'd1;
                  if (remaining == LastCount) r.ack_clear = 1'b1;
                end
                if (remaining == 0) begin
                  if (rx_len > 1) r.request_stop = 1'b1;
                  irq_on = 1'b0;
                  r.pos_clear = 1'b1;
                  phase = PhIdle;
                end
              end
            end
          end
        end
        CmdBusErr: begin
          irq_on = 1'b0;
          // bus error outranks ack failure, which outranks the rest
          if (it.error_flags[0]) begin
            phase = PhErr;
          end else if (it.error_flags[1]) begin
            r.request_stop = 1'b1;
            phase = PhIdle;
          end else if (it.error_flags[3:2] != 2'b00) begin
            phase = PhErr;
          end
        end
        default: ;
      endcase
      r.events_enabled = irq_on;
      r.phase_out = phase;
      pending_results.push_back(r);
    endfunction

    function void compare(string name, int unsigned exp, int unsigned act);
      if (exp != act) begin
        $error("%s: expected %0h, got %0h", name, exp, act);
        fails++;
      end
    endfunction

    function void check_result(logic [OutDataW-1:0] d);
      result_t e;
      if (pending_results.size() == 0) begin
        $error("result %0h arrived with nothing expected", d);
        fails++;
        return;
      end
      e = pending_results.pop_front();
      compare("start_accepted", e.start_accepted, d[0]);
      compare("write_valid", e.write_valid, d[1]);
      compare("write_byte", e.write_byte, d[9:2]);
      compare("store_valid", e.store_valid, d[10]);
      compare("store_index", e.store_index, d[18:11]);
      compare("store_byte", e.store_byte, d[26:19]);
      compare("request_stop", e.request_stop, d[27]);
      compare("ack_set", e.ack_set, d[28]);
      compare("ack_clear", e.ack_clear, d[29]);
      compare("pos_clear", e.pos_clear, d[30]);
      compare("events_enabled", e.events_enabled, d[31]);
      compare("phase_out", e.phase_out, d[33:32]);
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic [CmdW-1:0]      s_axis_tuser;
  logic [InDataW-1:0]   s_axis_tdata;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [OutDataW-1:0]  m_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i;
  logic [CfgDataW-1:0]  cfg_data_i;

  transfer_checker chk;
  logic src_idle;
  logic snk_idle;
  logic hold_req;
  logic hold_seen = 1'b0;
  int   hold_left = 0;

  i2c_master_transfer_sequencer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // status flags {start_sent, address_sent, byte_finished, tx_empty,
  // rx_not_empty} and error bits on top of random payload fields
  function automatic item_t ev(logic [4:0] f, logic [3:0] e);
    item_t      it;
    logic [31:0] w;
    w = $urandom();
    it = w[29:0];
    {it.start_sent, it.address_sent, it.byte_finished, it.tx_empty, it.rx_not_empty} = f;
    it.error_flags = e;
    return it;
  endfunction

  task automatic send_item(input logic [CmdW-1:0] cmd, input item_t it);
    if (src_idle) begin
      while ($urandom_range(99) < 28) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {2'b00, it.load_data, it.load_index, it.rx_data, it.error_flags,
                      it.rx_not_empty, it.tx_empty, it.byte_finished, it.address_sent,
                      it.start_sent};
    do @(posedge clk_i); while (!s_axis_tready);
    chk.take_command(cmd, it);
  endtask

  task automatic cfg_write(input cfg_reg_e idx, input logic [7:0] v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    chk.note_cfg(idx, v);
  endtask

  task automatic program_regs(input logic [7:0] addr, input logic [7:0] txl,
                              input logic [7:0] rxl, input logic rs);
    cfg_write(CfgTargetAddr, addr);
    cfg_write(CfgTxLength, txl);
    cfg_write(CfgRxLength, rxl);
    cfg_write(CfgRestart, {7'd0, rs});
    cfg_valid_i <= 1'b0;
  endtask

  // hold the sender back until every prediction has been answered
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (chk.pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // mostly events that fit the current phase, the rest anything at all
  function automatic void pick_item(output logic [CmdW-1:0] cmd, output item_t it);
    int roll;
    int sel;
    roll = $urandom_range(99);
    sel  = $urandom_range(9);
    it   = ev(5'($urandom_range(31)), 4'($urandom_range(15)));
    cmd  = CmdStatus;
    if (roll < 15) begin
      cmd = 3'($urandom_range(7));
    end else if (chk.phase == PhErr || (!chk.irq_on && chk.phase != PhIdle)) begin
      // recover through an ack failure
      cmd = CmdBusErr;
      it.error_flags[1:0] = 2'b10;
    end else if (roll < 25) begin
      cmd = CmdLoad;
    end else begin
      case (chk.phase)
        PhIdle: cmd = ($urandom_range(1) != 0) ? CmdStartRd : CmdStartWr;
        PhTx: begin
          if (sel == 0) it.start_sent = 1'b1;
          else if (sel == 1) {it.start_sent, it.address_sent} = 2'b01;
          else if (sel < 6)
            {it.start_sent, it.address_sent, it.byte_finished, it.tx_empty} = 4'b0001;
          else if (sel < 9)
            {it.start_sent, it.address_sent, it.byte_finished, it.tx_empty} = 4'b0011;
          else
            {it.start_sent, it.address_sent, it.byte_finished, it.tx_empty} = 4'b0010;
        end
        default: begin
          if (sel == 0) it.start_sent = 1'b1;
          else if (sel == 1) {it.start_sent, it.address_sent} = 2'b01;
          else if (sel < 4) {it.start_sent, it.address_sent, it.byte_finished} = 3'b001;
          else
            {it.start_sent, it.address_sent, it.byte_finished, it.rx_not_empty} = 4'b0001;
        end
      endcase
    end
  endfunction

  // result sink with random back-pressure and one long hold-off
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) chk.check_result(m_axis_tdata);
    if (hold_req && !hold_seen) begin
      hold_seen = 1'b1;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !snk_idle || ($urandom_range(99) >= 28);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    logic [CmdW-1:0] cmd;
    item_t           it;
    logic [7:0]      txl;
    logic [7:0]      rxl;
    chk = new();
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tuser  <= '0;
    s_axis_tdata  <= '0;
    m_axis_tready <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= CfgTargetAddr;
    cfg_data_i    <= '0;
    src_idle      <= 1'b0;
    snk_idle      <= 1'b0;
    hold_req      <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill the whole transmit store so no unwritten entry is ever read
    for (int i = 0; i < TxDepthDefault; i++) begin
      it = ev('0, '0);
      it.load_index = 5'(i);
      send_item(CmdLoad, it);
    end
    drain();

    program_regs(8'hA4, 8'd3, 8'd1, 1'b0);
    send_item(CmdStatus, ev(5'b11111, 4'h0));    // events still off
    send_item(CmdSpareLo, ev(5'b11111, 4'hF));
    send_item(CmdSpareHi, ev(5'b00000, 4'h0));
    // three-byte write with stop
    send_item(CmdStartWr, ev(5'b00000, 4'h0));
    send_item(CmdStartRd, ev(5'b00000, 4'h0));   // refused while busy
    send_item(CmdStatus, ev(5'b10000, 4'h0));
    send_item(CmdStatus, ev(5'b01000, 4'h0));
    send_item(CmdStatus, ev(5'b00101, 4'h0));    // byte finished without tx empty
    send_item(CmdStatus, ev(5'b00010, 4'h0));
    send_item(CmdStatus, ev(5'b00110, 4'h0));
    send_item(CmdStatus, ev(5'b00110, 4'h0));
    // single-byte read
    send_item(CmdStartRd, ev(5'b00000, 4'h0));
    send_item(CmdStatus, ev(5'b10000, 4'h0));
    send_item(CmdStatus, ev(5'b01000, 4'h0));
    it = ev(5'b00001, 4'h0);
    it.rx_data = 8'hFF;
    send_item(CmdStatus, it);
    // error handling
    send_item(CmdBusErr, ev(5'b00000, 4'h0));
    send_item(CmdStartWr, ev(5'b00000, 4'h0));
    send_item(CmdBusErr, ev(5'b00000, 4'hF));
    send_item(CmdStartRd, ev(5'b00000, 4'h0));
    send_item(CmdBusErr, ev(5'b00000, 4'h2));
    send_item(CmdBusErr, ev(5'b00000, 4'h8));
    send_item(CmdBusErr, ev(5'b00000, 4'h6));
    drain();

    for (int p = 0; p < 14; p++) begin
      txl = ($urandom_range(3) == 0) ? 8'($urandom_range(32, 7)) : 8'($urandom_range(6, 1));
      rxl = ($urandom_range(7) == 0) ? 8'($urandom_range(255, 7)) : 8'($urandom_range(6, 0));
      if (p == 0) program_regs(8'h00, 8'd0, 8'd0, 1'b0);
      else if (p == 1) program_regs(8'hFE, 8'd32, 8'd255, 1'b1);
      else program_regs(8'($urandom_range(254)), txl, rxl, 1'($urandom_range(1)));
      // phases 2 to 5 run without gaps; phase 5 also holds the sink off
      src_idle <= (p < 2 || p > 5);
      snk_idle <= (p < 2 || p > 5);
      if (p == 5) hold_req <= 1'b1;
      for (int k = 0; k < 28; k++) begin
        pick_item(cmd, it);
        send_item(cmd, it);
      end
      drain();
    end

    if (chk.fails == 0 && chk.pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
